// ----- hw/rtl/tfjv_pkg.sv -----
// Package for the token file JSON validator: status codes, parser phases,
// string phases and shared helper functions. No dependencies.
package tfjv_pkg;

    localparam int TOKEN_CHARS_DEF = 64;

    localparam logic [4:0] ST_OK          = 5'd0;
    localparam logic [4:0] ST_NOT_OBJECT  = 5'd1;
    localparam logic [4:0] ST_MISSING     = 5'd2;
    localparam logic [4:0] ST_EXP_STRING  = 5'd3;
    localparam logic [4:0] ST_EXP_COLON   = 5'd4;
    localparam logic [4:0] ST_CTRL_CHAR   = 5'd5;
    localparam logic [4:0] ST_UNTERM_ESC  = 5'd6;
    localparam logic [4:0] ST_BAD_ESC     = 5'd7;
    localparam logic [4:0] ST_BAD_UNI     = 5'd8;
    localparam logic [4:0] ST_NONASCII    = 5'd9;
    localparam logic [4:0] ST_UNTERM_STR  = 5'd10;
    localparam logic [4:0] ST_EXP_INT     = 5'd11;
    localparam logic [4:0] ST_INT_OVF     = 5'd12;
    localparam logic [4:0] ST_EXP_VALUE   = 5'd13;
    localparam logic [4:0] ST_UNSUP_VALUE = 5'd14;
    localparam logic [4:0] ST_EXP_COMMA   = 5'd15;
    localparam logic [4:0] ST_TRAILING    = 5'd16;
    localparam logic [4:0] ST_BAD_VERSION = 5'd17;
    localparam logic [4:0] ST_BAD_TYPE    = 5'd18;
    localparam logic [4:0] ST_BAD_TOKEN   = 5'd19;

    typedef enum logic [3:0] {
        PH_BEFORE, PH_FIRST_KEY, PH_KEY_STR, PH_COLON, PH_VALUE, PH_VAL_STR,
        PH_INT, PH_LITERAL, PH_AFTER_VAL, PH_NEXT_KEY, PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        SP_OUT, SP_IN, SP_ESC, SP_U0, SP_U1, SP_U2, SP_U3
    } sphase_t;

    localparam logic [1:0] TGT_NONE    = 2'd0;
    localparam logic [1:0] TGT_VERSION = 2'd1;
    localparam logic [1:0] TGT_TYPE    = 2'd2;
    localparam logic [1:0] TGT_TOKEN   = 2'd3;

    localparam logic [1:0] LIT_NONE  = 2'd0;
    localparam logic [1:0] LIT_TRUE  = 2'd1;
    localparam logic [1:0] LIT_FALSE = 2'd2;
    localparam logic [1:0] LIT_NULL  = 2'd3;

    // Front-to-back queue entry: one classified byte.
    typedef struct packed {
        logic       has_byte;
        logic       eof;
        logic [7:0] data;
    } fq_item_t;

    function automatic logic is_ws(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0d || b == 8'h0a;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] t;
        if (is_digit(b)) t = b - 8'h30;
        else if (b >= 8'h61) t = b - 8'h57;
        else t = b - 8'h37;
        return t[3:0];
    endfunction

    function automatic logic [7:0] key_char(input logic [1:0] k, input logic [3:0] i);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            2'd0: case (i)
                4'd0: c = "v"; 4'd1: c = "e"; 4'd2: c = "r"; 4'd3: c = "s";
                4'd4: c = "i"; 4'd5: c = "o"; 4'd6: c = "n";
                default: c = 8'h00;
            endcase
            2'd1: case (i)
                4'd0: c = "t"; 4'd1: c = "o"; 4'd2: c = "k"; 4'd3: c = "e";
                4'd4: c = "n"; 4'd5: c = "_"; 4'd6: c = "t"; 4'd7: c = "y";
                4'd8: c = "p"; 4'd9: c = "e";
                default: c = 8'h00;
            endcase
            2'd2: case (i)
                4'd0: c = "t"; 4'd1: c = "o"; 4'd2: c = "k"; 4'd3: c = "e";
                4'd4: c = "n";
                default: c = 8'h00;
            endcase
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] key_len(input logic [1:0] k);
        case (k)
            2'd0: return 4'd7;
            2'd1: return 4'd10;
            2'd2: return 4'd5;
            default: return 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] type_char(input logic [2:0] i);
        case (i)
            3'd0: return "B"; 3'd1: return "e"; 3'd2: return "a";
            3'd3: return "r"; 3'd4: return "e"; 3'd5: return "r";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] id, input logic [2:0] i);
        logic [7:0] c;
        c = 8'h00;
        case (id)
            LIT_TRUE: case (i)
                3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
                default: c = 8'h00;
            endcase
            LIT_FALSE: case (i)
                3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s";
                3'd4: c = "e";
                default: c = 8'h00;
            endcase
            LIT_NULL: case (i)
                3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
                default: c = 8'h00;
            endcase
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] id);
        case (id)
            LIT_TRUE:  return 3'd4;
            LIT_FALSE: return 3'd5;
            LIT_NULL:  return 3'd4;
            default:   return 3'd0;
        endcase
    endfunction

endpackage

// ----- hw/rtl/tfjv_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module tfjv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hw/rtl/tfjv_front.sv -----
// Front end: takes input items and queues them in a two-entry FIFO.
// Depends on tfjv_pkg.
module tfjv_front
    import tfjv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  fq_item_t   in_item,
    output logic       q_valid,
    input  logic       q_ready,
    output fq_item_t   q_item
);

    fq_item_t   buf_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = cnt_reg != 2'd2;
    assign q_valid  = cnt_reg != 2'd0;
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_item   = buf_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !in_ready) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("queue count");
`endif

endmodule

// ----- hw/rtl/tfjv_back.sv -----
// Back end: JSON parser state, token store, end checks and result emission.
// Depends on tfjv_pkg and tfjv_ram.
module tfjv_back
    import tfjv_pkg::*;
#(
    parameter int TOKEN_CHARS = TOKEN_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  fq_item_t    q_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  out_status,
    output logic [2:0]  out_index,
    output logic [63:0] out_chars,
    output logic        out_last
);

    localparam int AW     = $clog2(TOKEN_CHARS);
    localparam int LW     = $clog2(TOKEN_CHARS + 2);
    localparam int GROUPS = (TOKEN_CHARS + 7) / 8;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CW     = $clog2(GROUPS * 8 + 1);
    localparam logic [LW-1:0] TOK_N = LW'(TOKEN_CHARS);
    localparam logic [63:0] U64MAX = {64{1'b1}};
    localparam logic [63:0] LIM_HI = U64MAX / 64'd10;

    typedef enum logic [1:0] { EM_IDLE, EM_READ, EM_SEND } emit_t;

    phase_t      ph_reg, ph_next;
    sphase_t     sp_reg, sp_next;
    logic [15:0] uc_reg, uc_next;
    logic [1:0]  tgt_reg, tgt_next;
    logic [2:0]  km_reg, km_next;
    logic [3:0]  kl_reg, kl_next;
    logic [63:0] ver_reg, ver_next;
    logic [63:0] scr_reg, scr_next;
    logic [2:0]  seen_reg, seen_next;
    logic [LW-1:0] tl_reg, tl_next;
    logic        hex_reg, hex_next;
    logic [3:0]  tp_reg, tp_next;
    logic [1:0]  lid_reg, lid_next;
    logic [2:0]  lpos_reg, lpos_next;
    logic [4:0]  err_reg, err_next;

    // emission
    emit_t       em_reg, em_next;
    logic [GW-1:0] grp_reg, grp_next;
    logic [3:0]  bc_reg, bc_next;
    logic [63:0] word_reg, word_next;
    logic        ov_reg;
    logic [4:0]  os_reg;
    logic [2:0]  oi_reg;
    logic [63:0] oc_reg;
    logic        ol_reg;
    logic        ok_end;
    logic [4:0]  end_st;

    logic        take, wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]  wr_data, rd_data;
    logic [CW-1:0] rd_idx;
    logic        rd_ok_reg;

    tfjv_ram #(.WIDTH(8), .DEPTH(TOKEN_CHARS)) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // A result is pending when the emitter is busy or the output slot is full
    // and the next result can't move up.
    assign q_ready = (em_reg == EM_IDLE) && !(q_item.eof && ov_reg);
    assign take    = q_valid && q_ready;

    // End-of-file status from the post-byte parser state
    always_comb
    begin
        end_st = ST_OK;
        case (ph_next)
            PH_BEFORE: end_st = ST_NOT_OBJECT;
            PH_FIRST_KEY, PH_NEXT_KEY: end_st = ST_EXP_STRING;
            PH_KEY_STR, PH_VAL_STR:
                if (sp_next == SP_ESC) end_st = ST_UNTERM_ESC;
                else if (sp_next == SP_U0 || sp_next == SP_U1 || sp_next == SP_U2
                         || sp_next == SP_U3) end_st = ST_BAD_UNI;
                else end_st = ST_UNTERM_STR;
            PH_COLON: end_st = ST_EXP_COLON;
            PH_VALUE:
                if (tgt_next == TGT_VERSION) end_st = ST_EXP_INT;
                else if (tgt_next != TGT_NONE) end_st = ST_EXP_STRING;
                else end_st = ST_EXP_VALUE;
            PH_LITERAL: end_st = ST_UNSUP_VALUE;
            PH_INT, PH_AFTER_VAL: end_st = ST_EXP_COMMA;
            default:
                if (seen_next != 3'b111) end_st = ST_MISSING;
                else if (ver_next != 64'd1) end_st = ST_BAD_VERSION;
                else if (tp_next != 4'd6) end_st = ST_BAD_TYPE;
                else if (tl_next != TOK_N || !hex_next) end_st = ST_BAD_TOKEN;
                else end_st = ST_OK;
        endcase
        if (err_next != 5'd0) end_st = err_next;
        ok_end = end_st == ST_OK;
    end

    // Byte parser
    always_comb
    begin
        logic [7:0] b;
        logic [8:0] ch;
        logic       chv, cls;
        logic [4:0] f;
        phase_t     p;
        logic [63:0] acc, d;
        logic       use_ver;
        ph_next = ph_reg; sp_next = sp_reg; uc_next = uc_reg; tgt_next = tgt_reg;
        km_next = km_reg; kl_next = kl_reg; ver_next = ver_reg; scr_next = scr_reg;
        seen_next = seen_reg; tl_next = tl_reg; hex_next = hex_reg; tp_next = tp_reg;
        lid_next = lid_reg; lpos_next = lpos_reg; err_next = err_reg;
        wr_en = 1'b0; wr_addr = tl_reg[AW-1:0]; wr_data = 8'h00;
        b = q_item.data; ch = 9'd0; chv = 1'b0; cls = 1'b0; f = 5'd0;
        p = ph_reg; acc = 64'd0; d = 64'd0; use_ver = 1'b0;
        if (take && q_item.has_byte && err_reg == 5'd0)
        begin
            if (p == PH_INT && !is_digit(b)) p = PH_AFTER_VAL;
            // string decoder
            if (p == PH_KEY_STR || p == PH_VAL_STR)
            begin
                case (sp_reg)
                    SP_IN:
                        if (b == 8'h22) begin sp_next = SP_OUT; cls = 1'b1; end
                        else if (b < 8'h20) f = ST_CTRL_CHAR;
                        else if (b == 8'h5c) sp_next = SP_ESC;
                        else begin ch = {1'b0, b}; chv = 1'b1; end
                    SP_ESC:
                    begin
                        sp_next = SP_IN;
                        chv = 1'b1;
                        case (b)
                            8'h22, 8'h5c, 8'h2f: ch = {1'b0, b};
                            8'h62: ch = 9'h08;
                            8'h66: ch = 9'h0c;
                            8'h6e: ch = 9'h0a;
                            8'h72: ch = 9'h0d;
                            8'h74: ch = 9'h09;
                            8'h75: begin chv = 1'b0; uc_next = 16'd0; sp_next = SP_U0; end
                            default: begin chv = 1'b0; f = ST_BAD_ESC; end
                        endcase
                    end
                    SP_U0, SP_U1, SP_U2, SP_U3:
                        if (!is_hex(b)) f = ST_BAD_UNI;
                        else
                        begin
                            uc_next = {uc_reg[11:0], hex_val(b)};
                            case (sp_reg)
                                SP_U0: sp_next = SP_U1;
                                SP_U1: sp_next = SP_U2;
                                SP_U2: sp_next = SP_U3;
                                default:
                                begin
                                    sp_next = SP_IN;
                                    if (uc_next > 16'h7f) f = ST_NONASCII;
                                    else begin ch = {1'b0, uc_next[7:0]}; chv = 1'b1; end
                                end
                            endcase
                        end
                    default: ;
                endcase
            end
            case (p)
                PH_BEFORE:
                    if (!is_ws(b))
                    begin
                        if (b == 8'h7b) ph_next = PH_FIRST_KEY;
                        else f = ST_NOT_OBJECT;
                    end
                PH_FIRST_KEY, PH_NEXT_KEY:
                    if (!is_ws(b))
                    begin
                        if (b == 8'h22)
                        begin
                            sp_next = SP_IN; km_next = 3'b111; kl_next = 4'd0;
                            ph_next = PH_KEY_STR;
                        end
                        else if (b == 8'h7d && p == PH_FIRST_KEY) f = ST_MISSING;
                        else f = ST_EXP_STRING;
                    end
                PH_KEY_STR:
                    if (cls)
                    begin
                        tgt_next = TGT_NONE;
                        for (int i = 0; i < 3; i++)
                            if (km_reg[i] && kl_reg == key_len(2'(i))) tgt_next = 2'(i + 1);
                        ph_next = PH_COLON;
                    end
                    else if (chv)
                    begin
                        for (int i = 0; i < 3; i++)
                            if (kl_reg >= key_len(2'(i)) || key_char(2'(i), kl_reg) != ch[7:0])
                                km_next[i] = 1'b0;
                        if (kl_reg != 4'd15) kl_next = kl_reg + 4'd1;
                    end
                PH_COLON:
                    if (!is_ws(b))
                    begin
                        if (b == 8'h3a) ph_next = PH_VALUE;
                        else f = ST_EXP_COLON;
                    end
                PH_VALUE:
                    if (!is_ws(b))
                    begin
                        if (b == 8'h22 && tgt_reg != TGT_VERSION)
                        begin
                            sp_next = SP_IN; ph_next = PH_VAL_STR;
                            if (tgt_reg == TGT_TYPE) begin tp_next = 4'd0; seen_next[1] = 1'b1; end
                            if (tgt_reg == TGT_TOKEN)
                            begin
                                tl_next = '0; hex_next = 1'b1; seen_next[2] = 1'b1;
                            end
                        end
                        else if (is_digit(b) && (tgt_reg == TGT_VERSION || tgt_reg == TGT_NONE))
                        begin
                            ph_next = PH_INT;
                            if (tgt_reg == TGT_VERSION) seen_next[0] = 1'b1;
                            if (tgt_reg == TGT_VERSION) ver_next = {56'd0, b - 8'h30};
                            else scr_next = {56'd0, b - 8'h30};
                        end
                        else if (tgt_reg == TGT_VERSION) f = ST_EXP_INT;
                        else if (tgt_reg != TGT_NONE) f = ST_EXP_STRING;
                        else if (b == 8'h74) begin lid_next = LIT_TRUE; lpos_next = 3'd1; ph_next = PH_LITERAL; end
                        else if (b == 8'h66) begin lid_next = LIT_FALSE; lpos_next = 3'd1; ph_next = PH_LITERAL; end
                        else if (b == 8'h6e) begin lid_next = LIT_NULL; lpos_next = 3'd1; ph_next = PH_LITERAL; end
                        else f = ST_UNSUP_VALUE;
                    end
                PH_INT:
                begin
                    use_ver = tgt_reg == TGT_VERSION;
                    acc = use_ver ? ver_reg : scr_reg;
                    d = {56'd0, b - 8'h30};
                    // acc*10+d overflows iff acc > (max-d)/10
                    if (acc > LIM_HI || (acc == LIM_HI && d > 64'd5)) f = ST_INT_OVF;
                    else if (use_ver) ver_next = (acc << 3) + (acc << 1) + d;
                    else scr_next = (acc << 3) + (acc << 1) + d;
                end
                PH_VAL_STR:
                    if (cls) ph_next = PH_AFTER_VAL;
                    else if (chv)
                    begin
                        if (tgt_reg == TGT_TYPE)
                        begin
                            if (!tp_reg[3] && tp_reg[2:0] < 3'd6 && type_char(tp_reg[2:0]) == ch[7:0])
                                tp_next = {1'b0, tp_reg[2:0] + 3'd1};
                            else tp_next = tp_reg | 4'b1000;
                        end
                        else if (tgt_reg == TGT_TOKEN)
                        begin
                            if (tl_reg < TOK_N) begin wr_en = 1'b1; wr_data = ch[7:0]; end
                            if (tl_reg <= TOK_N) tl_next = tl_reg + LW'(1);
                            if (!is_hex(ch[7:0])) hex_next = 1'b0;
                        end
                    end
                PH_LITERAL:
                    if (lid_reg == LIT_NONE || lpos_reg >= lit_len(lid_reg)
                        || lit_char(lid_reg, lpos_reg) != b) f = ST_UNSUP_VALUE;
                    else if (lpos_reg + 3'd1 >= lit_len(lid_reg))
                    begin
                        lid_next = LIT_NONE; lpos_next = 3'd0; ph_next = PH_AFTER_VAL;
                    end
                    else lpos_next = lpos_reg + 3'd1;
                PH_AFTER_VAL:
                    if (!is_ws(b))
                    begin
                        if (b == 8'h7d) ph_next = PH_DONE;
                        else if (b == 8'h2c) ph_next = PH_NEXT_KEY;
                        else f = ST_EXP_COMMA;
                    end
                PH_DONE:
                    if (!is_ws(b)) f = ST_TRAILING;
                default: ;
            endcase
            if (p == PH_AFTER_VAL && ph_reg == PH_INT && ph_next == PH_INT) ph_next = PH_AFTER_VAL;
            if (f != 5'd0) err_next = f;
        end
    end

    // Emitter next state
    always_comb
    begin
        em_next = em_reg;
        case (em_reg)
            EM_IDLE: if (take && q_item.eof && ok_end) em_next = EM_READ;
            EM_READ: if (bc_reg == 4'd8) em_next = EM_SEND;
            EM_SEND:
                if (!ov_reg || out_ready)
                    em_next = (grp_reg == GW'(GROUPS - 1)) ? EM_IDLE : EM_READ;
            default: em_next = EM_IDLE;
        endcase
    end

    // Emitter datapath: one byte read per cycle, shifted into the word
    always_comb
    begin
        grp_next = grp_reg; bc_next = bc_reg; word_next = word_reg;
        rd_idx = CW'({grp_reg, 3'b000}) + CW'(bc_reg[2:0]);
        rd_addr = rd_idx[AW-1:0];
        case (em_reg)
            EM_IDLE:
            begin
                grp_next = '0; bc_next = 4'd0; word_next = 64'd0;
            end
            EM_READ:
            begin
                if (bc_reg != 4'd0)
                    word_next = {word_reg[55:0], rd_ok_reg ? rd_data : 8'h00};
                bc_next = bc_reg + 4'd1;
            end
            EM_SEND:
                if (!ov_reg || out_ready)
                begin
                    grp_next = grp_reg + GW'(1); bc_next = 4'd0; word_next = 64'd0;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_BEFORE; sp_reg <= SP_OUT; uc_reg <= '0; tgt_reg <= TGT_NONE;
            km_reg <= 3'b111; kl_reg <= '0; ver_reg <= '0; scr_reg <= '0; seen_reg <= '0;
            tl_reg <= '0; hex_reg <= 1'b1; tp_reg <= '0; lid_reg <= LIT_NONE;
            lpos_reg <= '0; err_reg <= '0;
            em_reg <= EM_IDLE; grp_reg <= '0; bc_reg <= '0; ov_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            em_reg  <= em_next;
            grp_reg <= grp_next;
            bc_reg  <= bc_next;
            rd_ok_reg <= rd_idx < CW'(TOKEN_CHARS);
            if (take && q_item.eof)
            begin
                ph_reg <= PH_BEFORE; sp_reg <= SP_OUT; uc_reg <= '0; tgt_reg <= TGT_NONE;
                km_reg <= 3'b111; kl_reg <= '0; ver_reg <= '0; scr_reg <= '0;
                seen_reg <= '0; tp_reg <= '0; lid_reg <= LIT_NONE; lpos_reg <= '0;
                err_reg <= '0;
                // token length and hex flag are still needed by nothing after
                // the check, so they clear here as well
                tl_reg <= '0; hex_reg <= 1'b1;
            end
            else
            begin
                ph_reg <= ph_next; sp_reg <= sp_next; uc_reg <= uc_next; tgt_reg <= tgt_next;
                km_reg <= km_next; kl_reg <= kl_next; ver_reg <= ver_next;
                scr_reg <= scr_next; seen_reg <= seen_next; tl_reg <= tl_next;
                hex_reg <= hex_next; tp_reg <= tp_next; lid_reg <= lid_next;
                lpos_reg <= lpos_next; err_reg <= err_next;
            end
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            if (take && q_item.eof && !ok_end) ov_reg <= 1'b1;
            if (em_reg == EM_SEND && (!ov_reg || out_ready)) ov_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (take && q_item.eof && !ok_end)
        begin
            os_reg <= end_st; oi_reg <= 3'd0; oc_reg <= 64'd0; ol_reg <= 1'b1;
        end
        else if (em_reg == EM_SEND && (!ov_reg || out_ready))
        begin
            os_reg <= ST_OK;
            oi_reg <= 3'(grp_reg);
            oc_reg <= word_reg;
            ol_reg <= grp_reg == GW'(GROUPS - 1);
        end
    end

    assign out_valid  = ov_reg;
    assign out_status = os_reg;
    assign out_index  = oi_reg;
    assign out_chars  = oc_reg;
    assign out_last   = ol_reg;

`ifndef SYNTHESIS
    a_ok_not_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == ST_OK |-> out_index < 3'(GROUPS) || GROUPS > 7)
        else $error("group index out of range");
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != ST_OK |-> out_last && out_chars == 64'd0)
        else $error("error result not single");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        em_reg != EM_IDLE |-> !q_ready) else $error("input taken while emitting");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_chars))
        else $error("result dropped");
`endif

endmodule

// ----- hw/rtl/token_file_json_validator.sv -----
// Token file JSON validator: parses a token file a byte per cycle, set by the byte
// parser; no byte is taken while the emitter is busy, nor an end-of-file item while
// the output slot is full. An end-of-file item that fails a check gives one error
// result; a good token gives one result per group of eight characters read from RAM.
// Reset: rst_n asynchronous, active low; parser returns to before the brace.
// Token RAM content is not reset; only bytes written by the current token are read.
module token_file_json_validator
    import tfjv_pkg::*;
#(
    parameter int TOKEN_CHARS = TOKEN_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // text_byte
    input  logic        s_axis_tuser,   // no_byte
    input  logic        s_axis_tlast,   // end_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // status[4:0], word_index[7:5], token_chars[71:8]
    output logic        m_axis_tlast    // last
);

    fq_item_t in_item, q_item;
    logic     q_valid, q_ready;
    logic [4:0]  st;
    logic [2:0]  wi;
    logic [63:0] tc;

    assign in_item.has_byte = ~s_axis_tuser;
    assign in_item.eof      = s_axis_tlast;
    assign in_item.data     = s_axis_tdata;

    // front: item queue
    tfjv_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    // back: parser and result emitter
    tfjv_back #(.TOKEN_CHARS(TOKEN_CHARS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_status(st),
        .out_index (wi),
        .out_chars (tc),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {tc, wi, st};

endmodule
